// File: src/bpm_pkg.sv
// Shared types and constants for the Bezier patch midpoint subdivider.
`default_nettype none
package bpm_pkg;

    localparam int CTRL_EDGE = 4;
    localparam int LEVELS_W  = 2;
    localparam int LV_W      = 3;
    localparam int FIELD_W   = 24;
    localparam int POS_W     = 5;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 80;
    localparam int KIND_W    = 2;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t CMD_LOAD  = 2'd0;
    localparam kind_t CMD_START = 2'd1;
    localparam kind_t CMD_READ  = 2'd2;

    localparam kind_t STAT_OK      = 2'd0;
    localparam kind_t STAT_DONE    = 2'd1;
    localparam kind_t STAT_OUTSIDE = 2'd2;

endpackage
`default_nettype wire

// File: src/bpm_grid_mem.sv
// Grid point memory with valid bits over the control point corner.
`default_nettype none
module bpm_grid_mem #(
    parameter int EDGE_MAX = 25,
    parameter int PW       = 72,
    parameter int LAW      = 5
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rd_en,
    input  logic [LAW-1:0] rd_row,
    input  logic [LAW-1:0] rd_col,
    output logic [PW-1:0]  rd_data,
    input  logic           wr_en,
    input  logic [LAW-1:0] wr_row,
    input  logic [LAW-1:0] wr_col,
    input  logic [PW-1:0]  wr_data
);
    import bpm_pkg::*;

    localparam int CELLS = EDGE_MAX * EDGE_MAX;
    localparam int AW    = $clog2(CELLS);

    logic [PW-1:0] mem [CELLS];
    logic [15:0]   valid_reg;
    logic [PW-1:0] rd_raw_reg;
    logic          rd_zero_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          rd_corner;
    logic          wr_corner;

    assign rd_addr   = AW'(rd_row) * AW'(EDGE_MAX) + AW'(rd_col);
    assign wr_addr   = AW'(wr_row) * AW'(EDGE_MAX) + AW'(wr_col);
    assign rd_corner = (int'(rd_row) < CTRL_EDGE) && (int'(rd_col) < CTRL_EDGE);
    assign wr_corner = (int'(wr_row) < CTRL_EDGE) && (int'(wr_col) < CTRL_EDGE);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_zero_reg <= 1'b1;
        end
        else
        begin
            if (rd_en)
            begin
                rd_zero_reg <= rd_corner && !valid_reg[{rd_row[1:0], rd_col[1:0]}];
            end
            if (wr_en && wr_corner)
            begin
                valid_reg[{wr_row[1:0], wr_col[1:0]}] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_zero_reg ? '0 : rd_raw_reg;

endmodule
`default_nettype wire

// File: src/bpm_line_mem.sv
// Line scratch memory with one write port and two registered read ports.
`default_nettype none
module bpm_line_mem #(
    parameter int EDGE_MAX = 25,
    parameter int PW       = 72,
    parameter int LAW      = 5
) (
    input  logic           clk,
    input  logic [LAW-1:0] rd_addr_a,
    input  logic [LAW-1:0] rd_addr_b,
    output logic [PW-1:0]  rd_data_a,
    output logic [PW-1:0]  rd_data_b,
    input  logic           wr_en,
    input  logic [LAW-1:0] wr_addr,
    input  logic [PW-1:0]  wr_data
);
    logic [PW-1:0] mem [EDGE_MAX];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule
`default_nettype wire

// File: src/bezier_patch_midpoint_subdivider.sv
// Top level: command decode, subdivision sequencer and result register.
//
//  channel  | direction | tuser          | tdata (lowest bits first)
//  s_axis   | in        | command        | row, col, x_in, y_in, z_in
//  m_axis   | out       | status         | x_out, y_out, z_out, grid_edge
//  cfg      | in        | -              | levels
//
// A read inside the grid passes the memory read register and the S_READ state before it
// presents its transaction, a read outside the grid right after the accepting edge.
// A start first sweeps the 3*2^MAX_LEVELS+1 square grid and clears it outside the corner,
// then runs every line split over the grid memory and the line memory: a read and a write
// state per point loaded, per midpoint and per point stored, with one memory access each.
// Reset clears the corner valid bits and the sequencer and sets the edge count to 4.
// Input is refused while a command runs or while the result register is full and not taken.
`default_nettype none
module bezier_patch_midpoint_subdivider #(
    parameter int MAX_LEVELS = 3,
    parameter int COORD_BITS = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bpm_pkg::LEVELS_W-1:0]         cfg_wdata,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // row, col, x_in, y_in, z_in
    input  logic [bpm_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // command
    input  logic [bpm_pkg::KIND_W-1:0]           s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // x_out, y_out, z_out, grid_edge
    output logic [bpm_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // status
    output logic [bpm_pkg::KIND_W-1:0]           m_axis_tuser
);
    import bpm_pkg::*;

    localparam int EDGE_MAX = 3 * (2 ** MAX_LEVELS) + 1;
    localparam int EW       = $clog2(EDGE_MAX + 1);
    localparam int IW       = EW + 1;
    localparam int LAW      = $clog2(EDGE_MAX);
    localparam int CW       = (EW > POS_W) ? EW : POS_W;
    localparam int CB       = COORD_BITS;
    localparam int PW       = 3 * CB;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_CLR, S_LD_RD, S_LD_WR, S_PY_RD, S_PY_WR, S_ST_RD, S_ST_WR
    } state_t;

    state_t               state_reg;
    logic [LEVELS_W-1:0]  levels_reg;
    logic [LV_W-1:0]      lv_reg;
    logic [LV_W-1:0]      lvt_reg;
    logic [EW-1:0]        n_reg;
    logic [EW-1:0]        fin_reg;
    logic [EW-1:0]        edge_reg;
    logic                 dir_reg;
    logic [EW-1:0]        line_reg;
    logic [EW-1:0]        i_reg;
    logic [EW-1:0]        p_reg;
    logic [EW-1:0]        j_reg;
    logic [LAW-1:0]       clr_r_reg;
    logic [LAW-1:0]       clr_c_reg;
    logic                 out_valid_reg;
    kind_t                out_status_reg;
    logic [PW-1:0]        out_point_reg;

    logic [POS_W-1:0]     in_row;
    logic [POS_W-1:0]     in_col;
    logic signed [FIELD_W-1:0] in_x;
    logic signed [FIELD_W-1:0] in_y;
    logic signed [FIELD_W-1:0] in_z;
    kind_t                in_cmd;
    logic                 accept;
    logic                 in_range;
    logic                 in_corner;
    logic [LV_W-1:0]      lv_sat;
    logic [IW-1:0]        num;
    logic [IW-1:0]        lim;
    logic [IW-1:0]        jp2;
    logic [LAW-1:0]       elem_row;
    logic [LAW-1:0]       elem_col;
    logic                 clr_corner;
    logic                 out_load;

    logic                 g_rd_en;
    logic [LAW-1:0]       g_rd_row;
    logic [LAW-1:0]       g_rd_col;
    logic [PW-1:0]        g_rd_data;
    logic                 g_wr_en;
    logic [LAW-1:0]       g_wr_row;
    logic [LAW-1:0]       g_wr_col;
    logic [PW-1:0]        g_wr_data;
    logic [LAW-1:0]       l_rd_a;
    logic [LAW-1:0]       l_rd_b;
    logic [PW-1:0]        l_data_a;
    logic [PW-1:0]        l_data_b;
    logic                 l_wr_en;
    logic [LAW-1:0]       l_wr_addr;
    logic [PW-1:0]        l_wr_data;
    logic [PW-1:0]        mid;
    logic [PW-1:0]        load_point;
    logic signed [CB-1:0] ox;
    logic signed [CB-1:0] oy;
    logic signed [CB-1:0] oz;

    assign in_row = s_axis_tdata[4:0];
    assign in_col = s_axis_tdata[9:5];
    assign in_x   = s_axis_tdata[33:10];
    assign in_y   = s_axis_tdata[57:34];
    assign in_z   = s_axis_tdata[81:58];
    assign in_cmd = s_axis_tuser;

    assign s_axis_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_range  = (CW'(in_row) < CW'(edge_reg)) && (CW'(in_col) < CW'(edge_reg));
    assign in_corner = (int'(in_row) < CTRL_EDGE) && (int'(in_col) < CTRL_EDGE);
    assign lv_sat    = (int'(levels_reg) > MAX_LEVELS) ? LV_W'(MAX_LEVELS) : LV_W'(levels_reg);

    assign num  = (IW'(n_reg) << 1) - IW'(1);
    assign lim  = (IW'(n_reg) << 1) - IW'(2) - IW'(p_reg);
    assign jp2  = IW'(j_reg) + IW'(2);
    assign elem_row = dir_reg ? LAW'(i_reg) : LAW'(line_reg);
    assign elem_col = dir_reg ? LAW'(line_reg) : LAW'(i_reg);
    assign clr_corner = (int'(clr_r_reg) < CTRL_EDGE) && (int'(clr_c_reg) < CTRL_EDGE);

    assign out_load = (state_reg == S_READ)
        || ((state_reg == S_IDLE) && accept && (in_cmd == CMD_READ) && !in_range)
        || ((state_reg == S_CLR) && (clr_c_reg == LAW'(EDGE_MAX - 1))
            && (clr_r_reg == LAW'(EDGE_MAX - 1)) && (lvt_reg == '0))
        || ((state_reg == S_ST_WR) && (IW'(i_reg) == num - IW'(1)) && dir_reg
            && (line_reg == fin_reg - EW'(1)) && (lv_reg + LV_W'(1) == lvt_reg));

    assign load_point = {CB'(in_z), CB'(in_y), CB'(in_x)};

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_mid
            logic signed [CB:0] sum;
            assign sum = (CB+1)'($signed(l_data_a[g*CB +: CB]))
                       + (CB+1)'($signed(l_data_b[g*CB +: CB]));
            assign mid[g*CB +: CB] = sum[CB:1];
        end
    endgenerate

    always_comb
    begin
        g_rd_en   = 1'b0;
        g_rd_row  = elem_row;
        g_rd_col  = elem_col;
        g_wr_en   = 1'b0;
        g_wr_row  = elem_row;
        g_wr_col  = elem_col;
        g_wr_data = l_data_a;
        l_rd_a    = LAW'(j_reg);
        l_rd_b    = LAW'(jp2);
        l_wr_en   = 1'b0;
        l_wr_addr = LAW'(IW'(i_reg) << 1);
        l_wr_data = g_rd_data;
        unique case (state_reg)
            S_IDLE:
            begin
                g_rd_row  = LAW'(in_row);
                g_rd_col  = LAW'(in_col);
                g_wr_row  = LAW'(in_row);
                g_wr_col  = LAW'(in_col);
                g_wr_data = load_point;
                g_rd_en   = accept && (in_cmd == CMD_READ) && in_range;
                g_wr_en   = accept && (in_cmd == CMD_LOAD) && in_corner;
            end
            S_CLR:
            begin
                g_wr_row  = clr_r_reg;
                g_wr_col  = clr_c_reg;
                g_wr_data = '0;
                g_wr_en   = !clr_corner;
            end
            S_LD_RD: g_rd_en = 1'b1;
            S_LD_WR: l_wr_en = 1'b1;
            S_PY_WR:
            begin
                l_wr_en   = 1'b1;
                l_wr_addr = LAW'(IW'(j_reg) + IW'(1));
                l_wr_data = mid;
            end
            S_ST_RD: l_rd_a = LAW'(i_reg);
            S_ST_WR: g_wr_en = 1'b1;
            default: ;
        endcase
    end

    bpm_grid_mem #(.EDGE_MAX(EDGE_MAX), .PW(PW), .LAW(LAW)) u_grid (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (g_rd_en),
        .rd_row  (g_rd_row),
        .rd_col  (g_rd_col),
        .rd_data (g_rd_data),
        .wr_en   (g_wr_en),
        .wr_row  (g_wr_row),
        .wr_col  (g_wr_col),
        .wr_data (g_wr_data)
    );

    bpm_line_mem #(.EDGE_MAX(EDGE_MAX), .PW(PW), .LAW(LAW)) u_line (
        .clk       (clk),
        .rd_addr_a (l_rd_a),
        .rd_addr_b (l_rd_b),
        .rd_data_a (l_data_a),
        .rd_data_b (l_data_b),
        .wr_en     (l_wr_en),
        .wr_addr   (l_wr_addr),
        .wr_data   (l_wr_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            levels_reg     <= '0;
            lv_reg         <= '0;
            lvt_reg        <= '0;
            n_reg          <= EW'(CTRL_EDGE);
            fin_reg        <= EW'(CTRL_EDGE);
            edge_reg       <= EW'(CTRL_EDGE);
            dir_reg        <= 1'b0;
            line_reg       <= '0;
            i_reg          <= '0;
            p_reg          <= '0;
            j_reg          <= '0;
            clr_r_reg      <= '0;
            clr_c_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STAT_OK;
            out_point_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                levels_reg <= cfg_wdata;
            end
            if (m_axis_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (in_cmd)
                            CMD_START:
                            begin
                                n_reg     <= EW'(CTRL_EDGE);
                                lv_reg    <= '0;
                                lvt_reg   <= lv_sat;
                                fin_reg   <= EW'((32'd3 << lv_sat) + 32'd1);
                                clr_r_reg <= '0;
                                clr_c_reg <= '0;
                                state_reg <= S_CLR;
                            end
                            CMD_READ:
                            begin
                                if (in_range)
                                begin
                                    state_reg <= S_READ;
                                end
                                else
                                begin
                                    out_valid_reg  <= 1'b1;
                                    out_status_reg <= STAT_OUTSIDE;
                                    out_point_reg  <= '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ:
                begin
                    out_valid_reg  <= 1'b1;
                    out_status_reg <= STAT_OK;
                    out_point_reg  <= g_rd_data;
                    state_reg      <= S_IDLE;
                end
                S_CLR:
                begin
                    if (clr_c_reg == LAW'(EDGE_MAX - 1))
                    begin
                        clr_c_reg <= '0;
                        if (clr_r_reg == LAW'(EDGE_MAX - 1))
                        begin
                            dir_reg  <= 1'b0;
                            line_reg <= '0;
                            i_reg    <= '0;
                            if (lvt_reg == '0)
                            begin
                                edge_reg       <= EW'(CTRL_EDGE);
                                out_valid_reg  <= 1'b1;
                                out_status_reg <= STAT_DONE;
                                out_point_reg  <= '0;
                                state_reg      <= S_IDLE;
                            end
                            else
                            begin
                                state_reg <= S_LD_RD;
                            end
                        end
                        else
                        begin
                            clr_r_reg <= clr_r_reg + LAW'(1);
                        end
                    end
                    else
                    begin
                        clr_c_reg <= clr_c_reg + LAW'(1);
                    end
                end
                S_LD_RD: state_reg <= S_LD_WR;
                S_LD_WR:
                begin
                    if (i_reg == n_reg - EW'(1))
                    begin
                        p_reg     <= '0;
                        j_reg     <= '0;
                        state_reg <= S_PY_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + EW'(1);
                        state_reg <= S_LD_RD;
                    end
                end
                S_PY_RD: state_reg <= S_PY_WR;
                S_PY_WR:
                begin
                    if (jp2 < lim)
                    begin
                        j_reg     <= EW'(jp2);
                        state_reg <= S_PY_RD;
                    end
                    else if (p_reg + EW'(1) == n_reg - EW'(1))
                    begin
                        i_reg     <= '0;
                        state_reg <= S_ST_RD;
                    end
                    else
                    begin
                        p_reg     <= p_reg + EW'(1);
                        j_reg     <= p_reg + EW'(1);
                        state_reg <= S_PY_RD;
                    end
                end
                S_ST_RD: state_reg <= S_ST_WR;
                S_ST_WR:
                begin
                    if (IW'(i_reg) == num - IW'(1))
                    begin
                        i_reg <= '0;
                        if (!dir_reg)
                        begin
                            state_reg <= S_LD_RD;
                            if (line_reg == n_reg - EW'(1))
                            begin
                                dir_reg  <= 1'b1;
                                line_reg <= '0;
                            end
                            else
                            begin
                                line_reg <= line_reg + EW'(1);
                            end
                        end
                        else if (line_reg == fin_reg - EW'(1))
                        begin
                            n_reg    <= EW'(num);
                            lv_reg   <= lv_reg + LV_W'(1);
                            dir_reg  <= 1'b0;
                            line_reg <= '0;
                            if (lv_reg + LV_W'(1) == lvt_reg)
                            begin
                                edge_reg       <= EW'(num);
                                out_valid_reg  <= 1'b1;
                                out_status_reg <= STAT_DONE;
                                out_point_reg  <= '0;
                                state_reg      <= S_IDLE;
                            end
                            else
                            begin
                                state_reg <= S_LD_RD;
                            end
                        end
                        else
                        begin
                            line_reg  <= line_reg + EW'(1);
                            state_reg <= S_LD_RD;
                        end
                    end
                    else
                    begin
                        i_reg     <= i_reg + EW'(1);
                        state_reg <= S_ST_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign ox = out_point_reg[0*CB +: CB];
    assign oy = out_point_reg[1*CB +: CB];
    assign oz = out_point_reg[2*CB +: CB];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {3'b000, POS_W'(edge_reg), FIELD_W'(oz), FIELD_W'(oy), FIELD_W'(ox)};

endmodule
`default_nettype wire

// File: src/bpm_checker.sv
// Port checker for the Bezier patch midpoint subdivider and its bind statement.
`default_nettype none
module bpm_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 s_axis_tvalid,
    input wire logic                                 s_axis_tready,
    input wire logic [bpm_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    input wire logic [bpm_pkg::KIND_W-1:0]           s_axis_tuser,
    input wire logic                                 m_axis_tvalid,
    input wire logic                                 m_axis_tready,
    input wire logic [bpm_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    input wire logic [bpm_pkg::KIND_W-1:0]           m_axis_tuser
);
    import bpm_pkg::*;

    logic [4:0] edge_out;
    assign edge_out = m_axis_tdata[76:72];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Result changed while stalled.");

    a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == STAT_DONE || m_axis_tuser == STAT_OUTSIDE)
        |-> m_axis_tdata[71:0] == 72'd0)
        else $error("Done or outside result carries coordinates.");

    a_edge_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (edge_out == 5'd4 || edge_out == 5'd7 ||
                           edge_out == 5'd13 || edge_out == 5'd25))
        else $error("Grid edge is not a subdivision size.");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_LOAD && !m_axis_tvalid
        |=> !m_axis_tvalid)
        else $error("Load produced a result.");

endmodule

bind bezier_patch_midpoint_subdivider bpm_checker u_bpm_checker (.*);
`default_nettype wire

// File: verif/tb_bezier_patch_midpoint_subdivider.sv
// Self-checking testbench for the Bezier patch midpoint subdivider.
`default_nettype none
module tb_bezier_patch_midpoint_subdivider;
    import bpm_pkg::*;

    localparam int EDGE_CAP = 25;
    localparam int CELL_CNT = EDGE_CAP * EDGE_CAP;
    localparam int CYCLE_LIMIT = 3000000;
    localparam kind_t CMD_UNUSED = 2'd3;

    typedef logic signed [FIELD_W-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        kind_t status;
        logic [POS_W-1:0] edge_pts;
    } grid_reply_t;

    class patch_scoreboard;
        coord_t gx[CELL_CNT];
        coord_t gy[CELL_CNT];
        coord_t gz[CELL_CNT];
        int edge_pts;
        int levels;
        int errors;
        grid_reply_t replies[$];

        function new();
            foreach (gx[k])
            begin
                gx[k] = '0;
                gy[k] = '0;
                gz[k] = '0;
            end
            edge_pts = CTRL_EDGE;
            levels = 0;
            errors = 0;
        endfunction

        function coord_t half_sum(coord_t a, coord_t b);
            logic signed [FIELD_W:0] s;
            s = a + b;
            return s[FIELD_W:1];
        endfunction

        function void split_line(int base, int step, int n);
            coord_t sx[EDGE_CAP];
            coord_t sy[EDGE_CAP];
            coord_t sz[EDGE_CAP];
            int num;
            num = 2 * n - 1;
            for (int i = 0; i < n; i++)
            begin
                sx[2 * i] = gx[base + i * step];
                sy[2 * i] = gy[base + i * step];
                sz[2 * i] = gz[base + i * step];
            end
            for (int i = 0; i + 1 < n; i++)
                for (int j = i; j + 1 + i < num; j += 2)
                begin
                    sx[j + 1] = half_sum(sx[j], sx[j + 2]);
                    sy[j + 1] = half_sum(sy[j], sy[j + 2]);
                    sz[j + 1] = half_sum(sz[j], sz[j + 2]);
                end
            for (int i = 0; i < num; i++)
            begin
                gx[base + i * step] = sx[i];
                gy[base + i * step] = sy[i];
                gz[base + i * step] = sz[i];
            end
        endfunction

        function void subdivide();
            int final_edge;
            int n;
            final_edge = 3 * (1 << levels) + 1;
            n = CTRL_EDGE;
            for (int r = 0; r < EDGE_CAP; r++)
                for (int c = 0; c < EDGE_CAP; c++)
                    if (r >= CTRL_EDGE || c >= CTRL_EDGE)
                    begin
                        gx[r * EDGE_CAP + c] = '0;
                        gy[r * EDGE_CAP + c] = '0;
                        gz[r * EDGE_CAP + c] = '0;
                    end
            for (int l = 0; l < levels; l++)
            begin
                for (int r = 0; r < n; r++)
                    split_line(r * EDGE_CAP, 1, n);
                for (int c = 0; c < final_edge; c++)
                    split_line(c, EDGE_CAP, n);
                n = 2 * n - 1;
            end
            edge_pts = n;
        endfunction

        function void note_command(kind_t cmd, int row, int col, coord_t x, coord_t y,
                                   coord_t z);
            grid_reply_t rep;
            rep = '0;
            if (cmd == CMD_LOAD)
            begin
                if (row < CTRL_EDGE && col < CTRL_EDGE)
                begin
                    gx[row * EDGE_CAP + col] = x;
                    gy[row * EDGE_CAP + col] = y;
                    gz[row * EDGE_CAP + col] = z;
                end
                return;
            end
            if (cmd == CMD_START)
            begin
                subdivide();
                rep.status = STAT_DONE;
            end
            else if (cmd == CMD_READ)
            begin
                if (row < edge_pts && col < edge_pts)
                begin
                    rep.x = gx[row * EDGE_CAP + col];
                    rep.y = gy[row * EDGE_CAP + col];
                    rep.z = gz[row * EDGE_CAP + col];
                    rep.status = STAT_OK;
                end
                else
                    rep.status = STAT_OUTSIDE;
            end
            else
                return;
            rep.edge_pts = edge_pts[POS_W-1:0];
            replies.push_back(rep);
        endfunction

        function void check_reply(grid_reply_t got);
            grid_reply_t want;
            if (replies.size() == 0)
            begin
                $display("%0t: unexpected transaction, actual %h", $time, got);
                errors++;
                return;
            end
            want = replies.pop_front();
            if (got.x !== want.x)
                $display("%0t: x mismatch, expected %h actual %h", $time, want.x, got.x);
            if (got.y !== want.y)
                $display("%0t: y mismatch, expected %h actual %h", $time, want.y, got.y);
            if (got.z !== want.z)
                $display("%0t: z mismatch, expected %h actual %h", $time, want.z, got.z);
            if (got.status !== want.status)
                $display("%0t: status mismatch, expected %0d actual %0d", $time,
                         want.status, got.status);
            if (got.edge_pts !== want.edge_pts)
                $display("%0t: grid_edge mismatch, expected %0d actual %0d", $time,
                         want.edge_pts, got.edge_pts);
            if (got !== want)
                errors++;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [LEVELS_W-1:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [KIND_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0] m_axis_tuser;

    patch_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int hold_cnt = 0;
    int cycles = 0;

    bezier_patch_midpoint_subdivider u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_command(s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[9:5],
                            s_axis_tdata[33:10], s_axis_tdata[57:34], s_axis_tdata[81:58]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_reply({m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tdata[71:48],
                            m_axis_tuser, m_axis_tdata[76:72]});
    end

    task automatic send_command(kind_t cmd, int row, int col, coord_t x, coord_t y,
                                coord_t z);
        while ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {6'd0, z, y, x, col[4:0], row[4:0]};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic write_levels(int value);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.replies.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value[LEVELS_W-1:0];
        sb.levels = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic coord_t pick_coord();
        case ($urandom_range(7))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2: return '0;
            default: return coord_t'($urandom);
        endcase
    endfunction

    task automatic run_patch();
        int span;
        int row;
        int col;
        if ($urandom_range(4) != 0)
            for (int r = 0; r < CTRL_EDGE; r++)
                for (int c = 0; c < CTRL_EDGE; c++)
                begin
                    send_command(CMD_LOAD, r, c, pick_coord(), pick_coord(), pick_coord());
                    if ($urandom_range(15) == 0)
                        send_command(kind_t'($urandom_range(3)), $urandom_range(31),
                                     $urandom_range(31), pick_coord(), pick_coord(),
                                     pick_coord());
                end
        send_command(CMD_START, $urandom_range(31), $urandom_range(31), pick_coord(),
                     pick_coord(), pick_coord());
        span = 3 * (1 << sb.levels) + 1;
        for (int k = 0; k < 25; k++)
        begin
            row = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(span - 1);
            col = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(span - 1);
            send_command(CMD_READ, row, col, pick_coord(), pick_coord(), pick_coord());
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(CMD_READ, 0, 0, '0, '0, '0);
        send_command(CMD_READ, 31, 31, 24'hffffff, 24'hffffff, 24'hffffff);
        for (int r = 0; r < CTRL_EDGE; r++)
            for (int c = 0; c < CTRL_EDGE; c++)
                send_command(CMD_LOAD, r, c, ((r + c) % 2) ? 24'h7fffff : 24'h800000,
                             (r % 2) ? 24'h800000 : 24'h7fffff, coord_t'(c * 24'h155555));
        send_command(CMD_LOAD, 4, 31, '1, '1, '1);
        send_command(CMD_UNUSED, 1, 1, '1, '1, '1);
        hold_cnt <= 2000;
        send_command(CMD_START, 0, 0, '0, '0, '0);
        send_command(CMD_READ, 3, 3, '0, '0, '0);
        send_command(CMD_READ, 4, 0, '0, '0, '0);
        send_command(CMD_READ, 1, 2, '0, '0, '0);
        write_levels(3);
        send_command(CMD_START, 0, 0, '0, '0, '0);
        send_command(CMD_READ, 24, 24, '0, '0, '0);
        send_command(CMD_READ, 25, 0, '0, '0, '0);
        send_command(CMD_READ, 12, 7, '0, '0, '0);

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle = (mode == 0) ? 32 : (mode == 1) ? 87 : 0;
            recv_idle = (mode == 0) ? 87 : (mode == 1) ? 32 : 0;
            for (int lv = 0; lv < 4; lv++)
            begin
                write_levels((lv + mode) % 4);
                for (int p = 0; p < 3; p++)
                    run_patch();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.replies.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
